// File: src/assert_macros.svh
// Assertion macros for the RTL of the decimal text writer.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: src/btda_pkg.sv
// Package of the decimal text writer: widths, character codes, state types.
// Used by btda_bcd_conv and binary_to_decimal_ascii_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package btda_pkg;

  localparam int ValueBits = 64;                  // width of the integer
  localparam int ValueW    = 64;                  // width of the value field
  localparam int DigitW    = 4;
  localparam int NumDigits = 20;                  // BCD digits held
  localparam int BcdW      = NumDigits * DigitW;
  localparam int BitCntW   = $clog2(ValueBits);
  localparam int CntW      = 5;                   // char_count width
  localparam int CharW     = 8;
  localparam int OutDataW  = 16;                  // char_code + char_count, byte padded

  localparam logic [CharW-1:0] DigitBase = 8'd48;  // '0'
  localparam logic [CharW-1:0] MinusCode = 8'd45;  // '-'

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_DABBLE,
    CV_TRIM,
    CV_HOLD
  } conv_state_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } top_state_e;

  // Requests from the emitter to the converter
  typedef struct packed {
    logic load;   // take a new magnitude
    logic pop;    // drop the leading digit
  } conv_ctrl_t;

  // Converter status back to the emitter
  typedef struct packed {
    logic            done;  // digits ready, leading zeros removed
    logic [CntW-1:0] ndig;  // significant digits
  } conv_stat_t;

endpackage

`default_nettype wire

// File: src/btda_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add 3) with leading-zero trim.
// Depends on btda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btda_bcd_conv (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  btda_pkg::conv_ctrl_t            ctrl_i,
  input  wire  [btda_pkg::ValueBits-1:0]        mag_i,
  output btda_pkg::conv_stat_t                  stat_o,
  output logic [btda_pkg::DigitW-1:0]           top_digit_o
);

  btda_pkg::conv_state_e state_q, state_d;

  logic [btda_pkg::ValueBits-1:0] mag_q, mag_d;
  logic [btda_pkg::BcdW-1:0]      bcd_q, bcd_d;
  logic [btda_pkg::BcdW-1:0]      bcd_adj;
  logic [btda_pkg::BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [btda_pkg::CntW-1:0]      ndig_q, ndig_d;
  logic                           top_zero;

  assign top_digit_o = bcd_q[btda_pkg::BcdW-1 -: btda_pkg::DigitW];
  assign top_zero    = (top_digit_o == '0);

  // Add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int i = 0; i < btda_pkg::NumDigits; i++) begin
      if (bcd_q[i*btda_pkg::DigitW +: btda_pkg::DigitW] >= 4'd5) begin
        bcd_adj[i*btda_pkg::DigitW +: btda_pkg::DigitW] =
          bcd_q[i*btda_pkg::DigitW +: btda_pkg::DigitW] + 4'd3;
      end else begin
        bcd_adj[i*btda_pkg::DigitW +: btda_pkg::DigitW] =
          bcd_q[i*btda_pkg::DigitW +: btda_pkg::DigitW];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      btda_pkg::CV_IDLE: begin
        if (ctrl_i.load) state_d = btda_pkg::CV_DABBLE;
      end
      btda_pkg::CV_DABBLE: begin
        if (bit_cnt_q == '0) state_d = btda_pkg::CV_TRIM;
      end
      btda_pkg::CV_TRIM: begin
        if (!top_zero || ndig_q == btda_pkg::CntW'(1)) state_d = btda_pkg::CV_HOLD;
      end
      btda_pkg::CV_HOLD: begin
        if (ctrl_i.load) state_d = btda_pkg::CV_DABBLE;
      end
      default: state_d = btda_pkg::CV_IDLE;
    endcase
  end

  // Datapath: load, shift one bit in, trim, pop one digit out
  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    if (ctrl_i.load) begin
      mag_d     = mag_i;
      bcd_d     = '0;
      bit_cnt_d = btda_pkg::BitCntW'(btda_pkg::ValueBits - 1);
      ndig_d    = btda_pkg::CntW'(btda_pkg::NumDigits);
    end else begin
      case (state_q)
        btda_pkg::CV_DABBLE: begin
          bcd_d     = {bcd_adj[btda_pkg::BcdW-2:0], mag_q[btda_pkg::ValueBits-1]};
          mag_d     = {mag_q[btda_pkg::ValueBits-2:0], 1'b0};
          bit_cnt_d = bit_cnt_q - btda_pkg::BitCntW'(1);
        end
        btda_pkg::CV_TRIM: begin
          if (top_zero && ndig_q != btda_pkg::CntW'(1)) begin
            bcd_d  = {bcd_q[btda_pkg::BcdW-btda_pkg::DigitW-1:0], {btda_pkg::DigitW{1'b0}}};
            ndig_d = ndig_q - btda_pkg::CntW'(1);
          end
        end
        btda_pkg::CV_HOLD: begin
          if (ctrl_i.pop) begin
            bcd_d = {bcd_q[btda_pkg::BcdW-btda_pkg::DigitW-1:0], {btda_pkg::DigitW{1'b0}}};
          end
        end
        default: begin
          bcd_d = bcd_q;
        end
      endcase
    end
  end

  // Status toward the emitter
  always_comb begin
    stat_o.done = (state_q == btda_pkg::CV_HOLD);
    stat_o.ndig = ndig_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btda_pkg::CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
  end

endmodule

`default_nettype wire

// File: src/binary_to_decimal_ascii_unit.sv
// Top level of the decimal text writer: input handshake, sign handling, emitter.
// Depends on btda_pkg, btda_bcd_conv and assert_macros.svh.
//
// Takes one signed 64-bit value per input item and sends its decimal text, most
// significant character first, one ASCII character per output item: '-' for a
// negative value, then the digits of the magnitude with no leading zeros, "0" for
// zero. tlast marks the final character, and every item carries the total
// character count (1 to 20). One value is worked on at a time: the shift-and-add-3
// converter takes one magnitude bit per cycle, then removes one leading zero digit
// per cycle, then the emitter sends one character per cycle while the output is
// taken. The next value is accepted as soon as the last character sits in the
// output register.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module binary_to_decimal_ascii_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_tvalid_i,
  output logic                                s_tready_o,
  input  wire  [btda_pkg::ValueW-1:0]         s_tdata_i,   // [63:0] value
  output logic                                m_tvalid_o,
  input  wire                                 m_tready_i,
  output logic [btda_pkg::OutDataW-1:0]       m_tdata_o,   // [7:0] char_code, [12:8] char_count
  output logic                                m_tlast_o    // last_char
);

  btda_pkg::top_state_e state_q, state_d;
  btda_pkg::conv_ctrl_t conv_ctrl;
  btda_pkg::conv_stat_t conv_stat;

  logic [btda_pkg::ValueBits-1:0] raw, mag;
  logic [btda_pkg::DigitW-1:0]    top_digit;
  logic                           accept, out_free, load_out, neg;
  logic                           sign_pend_q;
  logic [btda_pkg::CntW-1:0]      rem_q, total_q;
  logic                           m_tvalid_q, m_tlast_q;
  logic [btda_pkg::CharW-1:0]     char_q;
  logic [btda_pkg::CntW-1:0]      count_q;

  // Magnitude of the incoming value
  assign raw = s_tdata_i[btda_pkg::ValueBits-1:0];
  assign neg = raw[btda_pkg::ValueBits-1];
  assign mag = neg ? (~raw + btda_pkg::ValueBits'(1)) : raw;

  btda_bcd_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (conv_ctrl),
    .mag_i       (mag),
    .stat_o      (conv_stat),
    .top_digit_o (top_digit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      btda_pkg::ST_IDLE: begin
        if (accept) state_d = btda_pkg::ST_CONV;
      end
      btda_pkg::ST_CONV: begin
        if (conv_stat.done) state_d = btda_pkg::ST_EMIT;
      end
      btda_pkg::ST_EMIT: begin
        if (load_out && rem_q == btda_pkg::CntW'(1)) state_d = btda_pkg::ST_IDLE;
      end
      default: state_d = btda_pkg::ST_IDLE;
    endcase
  end

  // Handshake and converter requests
  always_comb begin
    s_tready_o     = (state_q == btda_pkg::ST_IDLE);
    accept         = s_tvalid_i && s_tready_o;
    out_free       = !m_tvalid_q || m_tready_i;
    load_out       = (state_q == btda_pkg::ST_EMIT) && out_free;
    conv_ctrl.load = accept;
    conv_ctrl.pop  = load_out && !sign_pend_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btda_pkg::ST_IDLE;
      m_tvalid_q  <= 1'b0;
      sign_pend_q <= 1'b0;
      rem_q       <= '0;
      total_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      // hold the sign until the minus is sent
      if (accept) begin
        sign_pend_q <= neg;
      end else if (load_out) begin
        sign_pend_q <= 1'b0;
      end
      // count characters left
      if (state_q == btda_pkg::ST_CONV && conv_stat.done) begin
        rem_q   <= conv_stat.ndig + btda_pkg::CntW'(sign_pend_q);
        total_q <= conv_stat.ndig + btda_pkg::CntW'(sign_pend_q);
      end else if (load_out) begin
        rem_q <= rem_q - btda_pkg::CntW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      char_q    <= sign_pend_q ? btda_pkg::MinusCode
                               : btda_pkg::DigitBase + btda_pkg::CharW'(top_digit);
      m_tlast_q <= (rem_q == btda_pkg::CntW'(1));
      count_q   <= total_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tlast_o  = m_tlast_q;
  assign m_tdata_o  = {{(btda_pkg::OutDataW - btda_pkg::CntW - btda_pkg::CharW){1'b0}},
                       count_q, char_q};

  // Checks
  `ASSERT_RST(a_emit_has_chars, clk_i, rst_ni, (state_q == btda_pkg::ST_EMIT) |-> (rem_q != '0), "emitting with no characters left")
  `ASSERT_RST(a_minus_not_last, clk_i, rst_ni, (load_out && sign_pend_q) |-> (rem_q > btda_pkg::CntW'(1)), "minus sign would end the text")
  `ASSERT_RST(a_char_legal, clk_i, rst_ni, m_tvalid_q |-> (char_q == btda_pkg::MinusCode || (char_q >= btda_pkg::DigitBase && char_q <= btda_pkg::DigitBase + 8'd9)), "character outside minus and digits")
  `ASSERT_NEVER(a_conv_done_idle, clk_i, rst_ni, (state_q == btda_pkg::ST_CONV) && $past(accept) && conv_stat.done, "converter reported done right after load")

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for binary_to_decimal_ascii_unit: decimal text of signed values.
// Depends on btda_pkg and the RTL of the unit; holds its own predictor of every character.
`timescale 1ns / 1ps

module tb;

  // One expected character of a value's text
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic [4:0] count;
  } char_item_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           s_tvalid_i = 1'b0;
  logic                           s_tready_o;
  logic [btda_pkg::ValueW-1:0]    s_tdata_i  = '0;   // [63:0] value
  logic                           m_tvalid_o;
  logic                           m_tready_i = 1'b0;
  logic [btda_pkg::OutDataW-1:0]  m_tdata_o;         // [7:0] char_code, [12:8] char_count
  logic                           m_tlast_o;         // last_char

  char_item_t expected_chars[$];
  int         error_count    = 0;
  int         values_sent    = 0;
  int         chars_checked  = 0;
  int         long_hold_left = 0;
  bit         idle_on        = 1'b1;

  binary_to_decimal_ascii_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Print one mismatch and count it
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Queue the characters of the decimal text of one value
  function automatic void predict_text(input logic [63:0] value);
    logic       neg;
    logic [63:0] mag;
    logic [7:0] digits [20];
    int         ndig;
    int         total;
    int         pos;
    char_item_t item;
    neg  = value[63];
    mag  = neg ? (~value + 64'd1) : value;
    ndig = 0;
    // least significant digit first
    do begin
      if (ndig < 20) begin
        digits[ndig] = btda_pkg::DigitBase + 8'(mag % 64'd10);
        ndig++;
      end
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    total = ndig + (neg ? 1 : 0);
    if (total > 20) total = 20;
    pos = 0;
    if (neg) begin
      item.code  = btda_pkg::MinusCode;
      item.last  = (total == 1);
      item.count = 5'(total);
      expected_chars.push_back(item);
      pos = 1;
    end
    for (int k = ndig - 1; k >= 0 && pos < total; k--) begin
      item.code  = digits[k];
      item.last  = (pos == total - 1);
      item.count = 5'(total);
      expected_chars.push_back(item);
      pos++;
    end
  endfunction

  // Offer one value, with an optional gap before it, and wait for the handshake
  task automatic send_value(input logic [63:0] value);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= {$urandom, $urandom};
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!s_tready_o);
    predict_text(value);
    values_sent++;
  endtask

  // Drop valid, wait for every pending character, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Random value of 1 to 19 digits with a random sign, a raw 64-bit pattern, or a power-of-ten boundary
  function automatic logic [63:0] random_value();
    logic [63:0] limit;
    logic [63:0] v;
    int          ndig;
    int          pick;
    pick = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if (pick < 70) begin
      ndig  = $urandom_range(1, 19);
      limit = 64'd1;
      repeat (ndig) limit = limit * 64'd10;
      if (ndig == 19) limit = 64'h8000_0000_0000_0000;
      v = v % limit;
      if ($urandom_range(0, 1)) v = ~v + 64'd1;
    end else if (pick < 85) begin
      // raw pattern keeps every bit toggling
    end else begin
      ndig  = $urandom_range(1, 18);
      limit = 64'd1;
      repeat (ndig) limit = limit * 64'd10;
      case ($urandom_range(0, 3))
        0: v = limit;
        1: v = limit - 64'd1;
        2: v = ~limit + 64'd1;
        default: v = ~(limit - 64'd1) + 64'd1;
      endcase
    end
    return v;
  endfunction

  // Extremes, zero, sign and digit-count boundaries
  task automatic test_directed();
    logic [63:0] edge_values [$];
    edge_values = '{64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd9, -64'sd10, 64'd99,
                    64'd100, -64'sd100, 64'd12345, -64'sd67890,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                    64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
                    64'd999999999999999999, 64'd1000000000000000000,
                    -64'sd999999999999999999, -64'sd1000000000000000000,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                    64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF};
    foreach (edge_values[i]) send_value(edge_values[i]);
  endtask

  // Random values with idling on both sides
  task automatic test_random_idle(input int n);
    repeat (n) send_value(random_value());
  endtask

  // Hold the output off for a long stretch while values keep coming
  task automatic test_backpressure();
    long_hold_left = 400;
    repeat (6) send_value(random_value());
  endtask

  // Pause the sender until every pending character has arrived
  task automatic test_drain_pause();
    repeat (5) send_value(random_value());
    drain_results();
    repeat (5) send_value(random_value());
  endtask

  // Full-rate stretch with no idling anywhere
  task automatic test_full_rate(input int n);
    idle_on = 1'b0;
    repeat (n) send_value(random_value());
  endtask

  // Output ready: long hold-off first, then random stall bursts while idling is on
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_left > 0) begin
        m_tready_i <= 1'b0;
        long_hold_left--;
      end else if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready_i <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk_i) begin : char_checker
    char_item_t want;
    if (rst_ni && m_tvalid_o === 1'b1 && m_tready_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h with nothing pending", m_tdata_o[7:0]));
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata_o[7:0] !== want.code)
          report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                    m_tdata_o[7:0], want.code));
        if (m_tdata_o[12:8] !== want.count)
          report_mismatch($sformatf("char_count %0d, want %0d", m_tdata_o[12:8], want.count));
        if (m_tlast_o !== want.last)
          report_mismatch($sformatf("last_char %b, want %b", m_tlast_o, want.last));
        if (m_tdata_o[15:13] !== 3'b000)
          report_mismatch($sformatf("padding bits %b not zero", m_tdata_o[15:13]));
        chars_checked++;
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_idle(120);
    test_backpressure();
    test_drain_pause();
    test_full_rate(120);
    drain_results();

    if (expected_chars.size() != 0) report_mismatch("characters still pending at the end");
    $display("Sent %0d values (extremes, every digit count, both signs, stalls and drains);",
             values_sent);
    $display("checked %0d characters with %0d mismatches.", chars_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
